>>> hw/rtl/array_list_with_cursor_macros.svh
// Assertion macros shared by the array list checker.
`ifndef ARRAY_LIST_WITH_CURSOR_MACROS_SVH
`define ARRAY_LIST_WITH_CURSOR_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ALC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define ALC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/alc_pkg.sv
// Package: sizes, action codes and cell control bundle for the array list.
package alc_pkg;

    localparam int CAPACITY  = 64;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIRST  = 2'd1,
        ACT_NEXT   = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        logic             ins;      // append at ins_idx
        logic             rem;      // close gap from rem_idx upward
        logic             rd;       // drive the read chain
        logic [IDX_W-1:0] ins_idx;
        logic [IDX_W-1:0] rem_idx;
        logic [IDX_W-1:0] rd_idx;
        logic [CNT_W-1:0] cnt;      // count before this action
    } cell_ctrl_t;

endpackage

>>> hw/rtl/array_list_with_cursor.sv
// Top level: bounded ordered list of data words with a read cursor.
//
// A bounded list of up to CAPACITY (64) words of DATA_BITS (32) bits, kept
// in a row of cells, one word per cell. Action insert appends data_in at the
// end (ok = 0 when full); first puts the cursor on entry 0 and returns it
// (ok = 0 when empty); next moves the cursor up one and returns that entry
// (ok = 0 on the last entry; with no cursor it starts at entry 0); remove
// returns the entry under the cursor, that cell and each live cell above it
// but the last take the upper neighbor's word in the same clock, and the
// cursor steps back (to "no position" when entry 0 was removed; ok = 0 with
// no cursor). data_out is zero on insert and on any failure; entry_count is
// the count after the action. One word per cycle is taken as long as the
// result register is free or being drained, so the rate is one word per
// clock, set by the cell update and the result register; a stall on the
// output holds the input off (in_stall follows out_stall while a result
// waits). An accepted input word's result is registered at the clock edge
// that accepts it. The read goes down the cell row as an AND-OR chain, so
// the path is one index compare plus a CAPACITY-deep OR.
module array_list_with_cursor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [alc_pkg::DATA_BITS-1:0] data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [alc_pkg::DATA_BITS-1:0] data_out,
    output logic [alc_pkg::CNT_W-1:0]     entry_count
);

    // control state
    logic [alc_pkg::CNT_W-1:0]     count_reg;
    logic [alc_pkg::CNT_W-1:0]     count_next;
    logic                          cur_valid_reg;
    logic                          cur_valid_next;
    logic [alc_pkg::IDX_W-1:0]     cur_idx_reg;
    logic [alc_pkg::IDX_W-1:0]     cur_idx_next;

    // result register
    logic                          out_valid_reg;
    logic                          ok_reg;
    logic                          ok_next;
    logic [alc_pkg::DATA_BITS-1:0] data_out_reg;
    logic [alc_pkg::CNT_W-1:0]     count_out_reg;

    logic                          accept;
    alc_pkg::action_t              act;
    alc_pkg::cell_ctrl_t           ctrl;
    logic                          next_fits;

    logic [alc_pkg::DATA_BITS-1:0] cell_data [alc_pkg::CAPACITY];
    logic [alc_pkg::DATA_BITS-1:0] rd_chain  [alc_pkg::CAPACITY+1];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign act      = alc_pkg::action_t'(action);

    // next succeeds when the cursor has a live entry above it, or with no cursor when the list is not empty
    assign next_fits = cur_valid_reg
        ? ((alc_pkg::CNT_W'(cur_idx_reg) + alc_pkg::CNT_W'(1)) < count_reg)
        : (count_reg != '0);

    always_comb
    begin
        ctrl           = '0;
        ctrl.cnt       = count_reg;
        ctrl.ins_idx   = count_reg[alc_pkg::IDX_W-1:0];
        ctrl.rem_idx   = cur_idx_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_idx_next   = cur_idx_reg;
        ok_next        = 1'b0;
        unique case (act)
            alc_pkg::ACT_INSERT:
            begin
                if (count_reg < alc_pkg::CNT_W'(alc_pkg::CAPACITY))
                begin
                    ok_next    = 1'b1;
                    ctrl.ins   = accept;
                    count_next = count_reg + alc_pkg::CNT_W'(1);
                end
            end
            alc_pkg::ACT_FIRST:
            begin
                if (count_reg != '0)
                begin
                    ok_next        = 1'b1;
                    ctrl.rd        = 1'b1;
                    ctrl.rd_idx    = '0;
                    cur_valid_next = 1'b1;
                    cur_idx_next   = '0;
                end
            end
            alc_pkg::ACT_NEXT:
            begin
                if (next_fits)
                begin
                    ok_next        = 1'b1;
                    ctrl.rd        = 1'b1;
                    ctrl.rd_idx    = cur_valid_reg
                                     ? cur_idx_reg + alc_pkg::IDX_W'(1) : '0;
                    cur_valid_next = 1'b1;
                    cur_idx_next   = ctrl.rd_idx;
                end
            end
            alc_pkg::ACT_REMOVE:
            begin
                if (cur_valid_reg && (alc_pkg::CNT_W'(cur_idx_reg) < count_reg))
                begin
                    ok_next        = 1'b1;
                    ctrl.rd        = 1'b1;
                    ctrl.rd_idx    = cur_idx_reg;
                    ctrl.rem       = accept;
                    count_next     = count_reg - alc_pkg::CNT_W'(1);
                    cur_valid_next = (cur_idx_reg != '0);
                    cur_idx_next   = cur_idx_reg - alc_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // cell row: cell g shifts from g+1, read chain runs from the top down
    assign rd_chain[alc_pkg::CAPACITY] = '0;

    for (genvar g = 0; g < alc_pkg::CAPACITY; g++)
    begin : g_cell
        logic [alc_pkg::DATA_BITS-1:0] upper;
        if (g == alc_pkg::CAPACITY - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cell_data[g+1];
        end

        alc_cell u_cell (
            .clk          (clk),
            .my_idx       (alc_pkg::IDX_W'(g)),
            .ctrl         (ctrl),
            .data_in      (data_in),
            .upper_data   (upper),
            .rd_chain_in  (rd_chain[g+1]),
            .entry        (cell_data[g]),
            .rd_chain_out (rd_chain[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                cur_valid_reg <= cur_valid_next;
                cur_idx_reg   <= cur_idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok_next;
            data_out_reg  <= rd_chain[0];
            count_out_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign data_out    = data_out_reg;
    assign entry_count = count_out_reg;

endmodule

>>> hw/rtl/alc_cell.sv
// One list slot: holds an entry, shifts down on remove, feeds the read chain.
module alc_cell (
    input  logic                          clk,
    input  logic [alc_pkg::IDX_W-1:0]     my_idx,
    input  alc_pkg::cell_ctrl_t           ctrl,
    input  logic [alc_pkg::DATA_BITS-1:0] data_in,
    input  logic [alc_pkg::DATA_BITS-1:0] upper_data,
    input  logic [alc_pkg::DATA_BITS-1:0] rd_chain_in,
    output logic [alc_pkg::DATA_BITS-1:0] entry,
    output logic [alc_pkg::DATA_BITS-1:0] rd_chain_out
);

    logic [alc_pkg::DATA_BITS-1:0] entry_reg;
    logic [alc_pkg::DATA_BITS-1:0] entry_next;
    logic                          take_ins;
    logic                          take_shift;
    logic                          rd_hit;

    assign take_ins   = ctrl.ins && (ctrl.ins_idx == my_idx);
    // shift when at or above the removed slot and not the last live entry
    assign take_shift = ctrl.rem && (my_idx >= ctrl.rem_idx)
                        && ((alc_pkg::CNT_W'(my_idx) + alc_pkg::CNT_W'(1)) < ctrl.cnt);
    assign rd_hit     = ctrl.rd && (ctrl.rd_idx == my_idx);

    always_comb
    begin
        entry_next = entry_reg;
        if (take_ins)
        begin
            entry_next = data_in;
        end
        else if (take_shift)
        begin
            entry_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry        = entry_reg;
    assign rd_chain_out = rd_chain_in | (rd_hit ? entry_reg : '0);

endmodule

>>> hw/rtl/alc_checker.sv
// Port-level checks for the array list, bound onto the top level.
`include "array_list_with_cursor_macros.svh"

module alc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [alc_pkg::DATA_BITS-1:0] data_out,
    input logic [alc_pkg::CNT_W-1:0]     entry_count
);

    `ALC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(ok) && $stable(data_out) && $stable(entry_count), "result word changed while stalled")
    `ALC_ASSERT(a_accept_gives_result, in_valid && !in_stall |=> out_valid, "accepted word produced no result")
    `ALC_ASSERT(a_stall_only_when_blocked, in_stall |-> out_valid && out_stall, "input stalled with output free")
    `ALC_ASSERT(a_count_bound, out_valid |-> entry_count <= alc_pkg::CNT_W'(alc_pkg::CAPACITY), "count beyond capacity")
    `ALC_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind array_list_with_cursor alc_checker u_alc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .data_out    (data_out),
    .entry_count (entry_count)
);
